// ----- hdl/lrck_pkg.sv -----
package lrck_pkg;

  localparam int KNOTS    = 16;
  localparam int KnotDen  = KNOTS - 1;
  localparam int KnotDen2 = 2 * KnotDen;

  localparam int IDX_W = 6;
  localparam int R_W   = 16;
  localparam int R2_W  = 31;
  localparam int CF_W  = 16;
  localparam int ACC_W = 20;
  localparam int OUT_W = 16;
  localparam int DEN_W = 22;
  localparam int DU_W  = 21;
  localparam int REM_W = 22;
  localparam int NUM_W = 29;

  localparam int NUM_MAIN = 8;
  localparam int NUM_DIV  = 8;

  localparam logic [OUT_W-1:0] ONE_Q14 = 16'd16384;
  localparam logic [OUT_W-1:0] OUT_MAX = 16'd65535;
  localparam logic signed [DEN_W-1:0] SAT_DEN = 22'sd4096;

  localparam int MODE_WARP = 0;
  localparam int MODE_VIG  = 1;

  localparam logic [2:0] REG_WARP0    = 3'd0;
  localparam logic [2:0] REG_WARP1    = 3'd1;
  localparam logic [2:0] REG_WARP2    = 3'd2;
  localparam logic [2:0] REG_VIG_LOW  = 3'd3;
  localparam logic [2:0] REG_VIG_HIGH = 3'd4;
  localparam logic [2:0] REG_DGAIN    = 3'd5;
  localparam logic [2:0] REG_VGAIN    = 3'd6;
  localparam logic [2:0] REG_MODE     = 3'd7;

  typedef logic [R_W-1:0] rad_lut_t [2**IDX_W];

  // Knot radius in Q1.15, indexes past the last knot read as the last knot.
  // The rounded quotient is formed by shift and subtract.
  function automatic rad_lut_t build_rad_lut();
    rad_lut_t lut;
    int ic;
    int num;
    int quo;
    for (int i = 0; i < 2**IDX_W; i++) begin
      ic  = (i > KnotDen) ? KnotDen : i;
      num = ic * 65536 + KnotDen;
      quo = 0;
      for (int b = 22; b >= 0; b--) begin
        if (num >= (KnotDen2 << b)) begin
          num = num - (KnotDen2 << b);
          quo = quo + (1 << b);
        end
      end
      lut[i] = R_W'(quo);
    end
    return lut;
  endfunction

  localparam rad_lut_t RAD_LUT = build_rad_lut();

  typedef struct packed {
    logic [IDX_W-1:0]            idx;
    logic [R_W-1:0]              r;
    logic [R2_W-1:0]             r2;
    logic [2:0][ACC_W-1:0]       accw;
    logic signed [ACC_W-1:0]     accv;
    logic [2:0][OUT_W-1:0]       cor;
    logic signed [DEN_W-1:0]     den;
    logic                        vig_on;
  } mp_t;

  typedef struct packed {
    logic [R_W-1:0]        r;
    logic [2:0][OUT_W-1:0] cor;
    logic                  vig_on;
    logic                  sat;
    logic [DU_W-1:0]       du;
    logic [REM_W-1:0]      rem;
    logic [OUT_W-1:0]      nlow;
    logic [OUT_W-1:0]      quo;
    logic [OUT_W-1:0]      vig;
  } rc_t;

  function automatic logic signed [CF_W-1:0] coef(logic [63:0] w, int j);
    return $signed(w[16*j +: 16]);
  endfunction

  // round(r2 * acc / 2^30), half away from zero.
  function automatic logic signed [DEN_W-1:0] rnd30(logic [R2_W-1:0] r2,
                                                    logic signed [ACC_W-1:0] acc);
    logic signed [R2_W+ACC_W:0] prod;
    logic signed [R2_W+ACC_W:0] negc;
    logic signed [R2_W+ACC_W:0] adj;
    prod = $signed({1'b0, r2}) * acc;
    negc = prod[R2_W+ACC_W] ? 52'sd1 : 52'sd0;
    adj  = prod + 52'sd536870912 - negc;
    return DEN_W'(adj >>> 30);
  endfunction

  function automatic logic signed [ACC_W-1:0] horner_step(logic signed [CF_W-1:0] k,
                                                          logic [R2_W-1:0] r2,
                                                          logic signed [ACC_W-1:0] acc);
    logic signed [DEN_W-1:0] t;
    t = rnd30(r2, acc);
    return ACC_W'(k) + ACC_W'(t);
  endfunction

  // 1 + gain * (poly - 1), clamped to the unsigned Q2.14 range.
  function automatic logic [OUT_W-1:0] dist_out(logic signed [CF_W-1:0] gain,
                                                logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W:0]  diff;
    logic signed [36:0]     prod;
    logic signed [36:0]     negc;
    logic signed [36:0]     sum;
    diff = (ACC_W+1)'(acc) - 21'sd16384;
    prod = gain * diff;
    negc = prod[36] ? 37'sd1 : 37'sd0;
    sum  = ((prod + 37'sd8192 - negc) >>> 14) + 37'sd16384;
    if (sum < 37'sd0) begin
      return '0;
    end else if (sum > 37'sd65535) begin
      return OUT_MAX;
    end
    return sum[OUT_W-1:0];
  endfunction

  function automatic logic signed [DEN_W-1:0] den_calc(logic signed [CF_W-1:0] gain,
                                                       logic signed [DEN_W-1:0] d);
    logic signed [37:0] prod;
    logic signed [37:0] negc;
    logic signed [37:0] sh;
    prod = gain * d;
    negc = prod[37] ? 38'sd1 : 38'sd0;
    sh   = (prod + 38'sd8192 - negc) >>> 14;
    return DEN_W'(sh) + 22'sd16384;
  endfunction

endpackage

// ----- hdl/lens_radial_correction_knots.sv -----
// Radial lens correction per knot. Each input beat carries a knot index; the
// block answers with one output beat holding the knot radius, the red, green
// and blue distortion factors and the vignette gain.
// Registers are written through cfg_we_i / cfg_idx_i / cfg_data_i; the user must
// write only while no beat is in flight, unenforced here; beats accepted afterwards see them.
// An accepted input beat passes eight main stages (index register, radius
// lookup and square, three Horner steps, the distortion factors beside the last
// vignette step, the vignette rounding and the vignette gain product), then
// eight stages of a radix-4 restoring divider for the vignette reciprocal,
// before it leaves as its output beat.
// Throughput is one beat per cycle. Every stage has its own valid bit and
// moves whenever the stage after it is free, so a stalled receiver holds the
// output beat while bubbles upstream still fill; input is taken until every
// stage holds a beat.
// Reset empties the pipeline and loads the register defaults: both gains at
// 1.0, all coefficients zero and both corrections disabled.
module lens_radial_correction_knots import lrck_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // knot_index
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // radius, cor_red, cor_green, cor_blue, vignette_factor
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  logic [2:0][63:0]        warp_q;
  logic [63:0]             vig_low_q;
  logic signed [CF_W-1:0]  vig_high_q;
  logic signed [CF_W-1:0]  dgain_q;
  logic signed [CF_W-1:0]  vgain_q;
  logic [3:0]              mode_q;

  logic [2:0][63:0]        wsel;
  logic [1:0]              planes;

  logic [NUM_MAIN-1:0]     v_q;
  logic [NUM_MAIN-1:0]     en;
  mp_t                     p_q [NUM_MAIN];
  mp_t                     p_d [NUM_MAIN];

  logic                    rc_ready;
  rc_t                     rc_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warp_q     <= '0;
      vig_low_q  <= '0;
      vig_high_q <= '0;
      dgain_q    <= 16'sd16384;
      vgain_q    <= 16'sd16384;
      mode_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WARP0:    warp_q[0]  <= cfg_data_i;
        REG_WARP1:    warp_q[1]  <= cfg_data_i;
        REG_WARP2:    warp_q[2]  <= cfg_data_i;
        REG_VIG_LOW:  vig_low_q  <= cfg_data_i;
        REG_VIG_HIGH: vig_high_q <= cfg_data_i[CF_W-1:0];
        REG_DGAIN:    dgain_q    <= cfg_data_i[CF_W-1:0];
        REG_VGAIN:    vgain_q    <= cfg_data_i[CF_W-1:0];
        REG_MODE:     mode_q     <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // With more than one plane, channel c takes plane min(c, planes-1).
  assign planes = mode_q[3:2];
  always_comb begin
    wsel[0] = warp_q[0];
    wsel[1] = (planes > 2'd1) ? warp_q[1] : warp_q[0];
    if (planes == 2'd3) begin
      wsel[2] = warp_q[2];
    end else if (planes == 2'd2) begin
      wsel[2] = warp_q[1];
    end else begin
      wsel[2] = warp_q[0];
    end
  end

  always_comb begin
    en[NUM_MAIN-1] = !v_q[NUM_MAIN-1] || rc_ready;
    for (int k = NUM_MAIN - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end

    p_d[0]     = '0;
    p_d[0].idx = s_axis_tdata[IDX_W-1:0];

    p_d[1]      = p_q[0];
    p_d[1].r    = RAD_LUT[p_q[0].idx];
    p_d[1].r2   = R2_W'(p_d[1].r * p_d[1].r);
    for (int c = 0; c < 3; c++) begin
      p_d[1].accw[c] = ACC_W'(coef(wsel[c], 3));
    end
    p_d[1].accv = ACC_W'(vig_high_q);

    p_d[2] = p_q[1];
    p_d[3] = p_q[2];
    p_d[4] = p_q[3];
    for (int c = 0; c < 3; c++) begin
      p_d[2].accw[c] = horner_step(coef(wsel[c], 2), p_q[1].r2, $signed(p_q[1].accw[c]));
      p_d[3].accw[c] = horner_step(coef(wsel[c], 1), p_q[2].r2, $signed(p_q[2].accw[c]));
      p_d[4].accw[c] = horner_step(coef(wsel[c], 0), p_q[3].r2, $signed(p_q[3].accw[c]));
    end
    p_d[2].accv = horner_step(coef(vig_low_q, 3), p_q[1].r2, p_q[1].accv);
    p_d[3].accv = horner_step(coef(vig_low_q, 2), p_q[2].r2, p_q[2].accv);
    p_d[4].accv = horner_step(coef(vig_low_q, 1), p_q[3].r2, p_q[3].accv);

    p_d[5] = p_q[4];
    for (int c = 0; c < 3; c++) begin
      p_d[5].cor[c] = mode_q[MODE_WARP] ?
                      dist_out(dgain_q, $signed(p_q[4].accw[c])) : ONE_Q14;
    end
    p_d[5].accv = horner_step(coef(vig_low_q, 0), p_q[4].r2, p_q[4].accv);

    // The vignette polynomial carries one more factor of r2 than its Horner chain.
    p_d[6]     = p_q[5];
    p_d[6].den = rnd30(p_q[5].r2, p_q[5].accv);

    p_d[7]        = p_q[6];
    p_d[7].den    = den_calc(vgain_q, p_q[6].den);
    p_d[7].vig_on = mode_q[MODE_VIG];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NUM_MAIN; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_MAIN; k++) begin
      if (en[k]) begin
        p_q[k] <= p_d[k];
      end
    end
  end

  assign s_axis_tready = en[0];

  lrck_recip u_recip (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v_q[NUM_MAIN-1]),
    .in_ready_o  (rc_ready),
    .in_data_i   (p_q[NUM_MAIN-1]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (rc_out)
  );

  assign m_axis_tdata = {rc_out.vig, rc_out.cor[2], rc_out.cor[1], rc_out.cor[0], rc_out.r};

endmodule

// ----- hdl/lrck_recip.sv -----
module lrck_recip import lrck_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  mp_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rc_t  out_data_o
);

  logic [NUM_DIV-1:0] v_q;
  logic [NUM_DIV-1:0] en;
  rc_t                p_q [NUM_DIV];
  rc_t                p_d [NUM_DIV];
  rc_t                init;
  logic [NUM_W-1:0]   num;

  // Two quotient bits of restoring division.
  function automatic rc_t div2(rc_t p);
    rc_t              o;
    logic [REM_W-1:0] t;
    o = p;
    for (int j = 0; j < 2; j++) begin
      t      = {o.rem[REM_W-2:0], o.nlow[OUT_W-1]};
      o.nlow = {o.nlow[OUT_W-2:0], 1'b0};
      if (t >= {1'b0, o.du}) begin
        o.rem = t - {1'b0, o.du};
        o.quo = {o.quo[OUT_W-2:0], 1'b1};
      end else begin
        o.rem = t;
        o.quo = {o.quo[OUT_W-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  // Any denominator up to 4096 rounds to a quotient of 65536 or more.
  always_comb begin
    init        = '0;
    init.r      = in_data_i.r;
    init.cor    = in_data_i.cor;
    init.vig_on = in_data_i.vig_on;
    init.sat    = (in_data_i.den <= SAT_DEN);
    init.du     = in_data_i.den[DU_W-1:0];
    num         = {1'b1, {(NUM_W-1){1'b0}}} + NUM_W'(init.du >> 1);
    init.rem    = REM_W'(num[NUM_W-1:OUT_W]);
    init.nlow   = num[OUT_W-1:0];
  end

  always_comb begin
    en[NUM_DIV-1] = !v_q[NUM_DIV-1] || out_ready_i;
    for (int k = NUM_DIV - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    p_d[0] = div2(init);
    for (int k = 1; k < NUM_DIV; k++) begin
      p_d[k] = div2(p_q[k-1]);
    end
    if (!p_d[NUM_DIV-1].vig_on) begin
      p_d[NUM_DIV-1].vig = ONE_Q14;
    end else if (p_d[NUM_DIV-1].sat) begin
      p_d[NUM_DIV-1].vig = OUT_MAX;
    end else begin
      p_d[NUM_DIV-1].vig = p_d[NUM_DIV-1].quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NUM_DIV; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_DIV; k++) begin
      if (en[k]) begin
        p_q[k] <= p_d[k];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NUM_DIV-1];
  assign out_data_o  = p_q[NUM_DIV-1];

endmodule

// ----- sim/lrck_checker.sv -----
`timescale 1ns / 1ps

module lrck_checker import lrck_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // knot_index
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [79:0] m_axis_tdata,   // radius, cor_red, cor_green, cor_blue, vignette_factor
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          seen_o
);

  typedef struct {
    logic [15:0] radius;
    logic [15:0] cor [3];
    logic [15:0] vig;
  } knot_result_t;

  knot_result_t expected_q [$];
  logic [63:0] plane_words [3];
  logic [63:0] vig_low;
  longint vig_high, dist_gain, vig_gain;
  logic [3:0] mode;

  function automatic longint sx16(logic [63:0] v);
    return longint'($signed(v[15:0]));
  endfunction

  // Divide by 2^s with rounding half away from zero.
  function automatic longint rshift_round(longint v, int s);
    longint h;
    h = longint'(1) << (s - 1);
    if (v >= 0) return (v + h) >>> s;
    return -((-v + h) >>> s);
  endfunction

  function automatic longint clamp16(longint v);
    if (v < 0) return 0;
    if (v > 65535) return 65535;
    return v;
  endfunction

  function automatic knot_result_t compute_knot(logic [5:0] knot);
    knot_result_t res;
    longint idx, r, r2, acc, d, den, q;
    int plane, planes;
    idx = longint'(knot);
    if (idx > KNOTS - 1) idx = KNOTS - 1;
    r = (idx * 65536 + (KNOTS - 1)) / (2 * (KNOTS - 1));
    r2 = r * r;
    res.radius = r[15:0];
    planes = int'(mode[3:2]);
    for (int c = 0; c < 3; c++) begin
      if (mode[0]) begin
        plane = 0;
        if (planes > 1) plane = (c > planes - 1) ? planes - 1 : c;
        acc = sx16(plane_words[plane] >> 48);
        for (int j = 2; j >= 0; j--)
          acc = sx16(plane_words[plane] >> (16 * j)) + rshift_round(r2 * acc, 30);
        res.cor[c] = 16'(clamp16(16384 + rshift_round(dist_gain * (acc - 16384), 14)));
      end else begin
        res.cor[c] = ONE_Q14;
      end
    end
    if (mode[1]) begin
      acc = vig_high;
      for (int j = 3; j >= 0; j--)
        acc = sx16(vig_low >> (16 * j)) + rshift_round(r2 * acc, 30);
      d = rshift_round(r2 * acc, 30);
      den = 16384 + rshift_round(vig_gain * d, 14);
      if (den <= 0) begin
        res.vig = OUT_MAX;
      end else begin
        q = ((longint'(1) << 28) + den / 2) / den;
        res.vig = 16'(clamp16(q));
      end
    end else begin
      res.vig = ONE_Q14;
    end
    return res;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    knot_result_t want;
    logic [15:0] got [5];
    if (!rst_ni) begin
      for (int p = 0; p < 3; p++) plane_words[p] = '0;
      vig_low = '0;
      vig_high = 0;
      dist_gain = 16384;
      vig_gain = 16384;
      mode = '0;
      fail_count_o <= 0;
      seen_o <= 0;
      expected_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen_o <= seen_o + 1;
        for (int f = 0; f < 5; f++) got[f] = m_axis_tdata[16*f +: 16];
        if (expected_q.size() == 0) begin
          $error("output beat with no expected result: %h", m_axis_tdata);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (got[0] !== want.radius || got[1] !== want.cor[0] ||
              got[2] !== want.cor[1] || got[3] !== want.cor[2] || got[4] !== want.vig) begin
            fail_count_o <= fail_count_o + 1;
            if (got[0] !== want.radius)
              $error("radius: expected %0d, got %0d", want.radius, got[0]);
            if (got[1] !== want.cor[0])
              $error("cor_red: expected %0d, got %0d", want.cor[0], got[1]);
            if (got[2] !== want.cor[1])
              $error("cor_green: expected %0d, got %0d", want.cor[1], got[2]);
            if (got[3] !== want.cor[2])
              $error("cor_blue: expected %0d, got %0d", want.cor[2], got[3]);
            if (got[4] !== want.vig)
              $error("vignette_factor: expected %0d, got %0d", want.vig, got[4]);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(compute_knot(s_axis_tdata[5:0]));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WARP0:    plane_words[0] = cfg_data_i;
          REG_WARP1:    plane_words[1] = cfg_data_i;
          REG_WARP2:    plane_words[2] = cfg_data_i;
          REG_VIG_LOW:  vig_low = cfg_data_i;
          REG_VIG_HIGH: vig_high = sx16(cfg_data_i);
          REG_DGAIN:    dist_gain = sx16(cfg_data_i);
          REG_VGAIN:    vig_gain = sx16(cfg_data_i);
          REG_MODE:     mode = cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top import lrck_pkg::*;;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // knot_index
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;        // radius, cor_red, cor_green, cor_blue, vignette_factor
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;

  int fail_count, pending, seen, knots_sent, cycles;
  bit hold_off = 1'b0;

  always #5 clk_i = ~clk_i;

  lens_radial_correction_knots i_dut (.*);

  lrck_checker i_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_idx_i,
    .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending), .seen_o(seen)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: stretches of random stalls, stretches always ready, and a long
  // hold-off on request so the pipeline backs up into the input.
  initial begin
    int mode_len, stall_pct;
    forever begin
      mode_len = $urandom_range(5, 80);
      stall_pct = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(10, 80);
      repeat (mode_len) begin
        @(negedge clk_i);
        if (hold_off) begin
          m_axis_tready <= 1'b0;
          repeat (200) @(negedge clk_i);
          hold_off = 1'b0;
        end
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Called at a falling edge; returns after the beat is taken, at the next one.
  task automatic send_knot(logic [5:0] knot);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, knot};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    knots_sent++;
  endtask

  task automatic send_burst(int count, bit full_range);
    int left, burst;
    left = count;
    @(negedge clk_i);
    while (left > 0) begin
      burst = $urandom_range(1, 30);
      for (int b = 0; b < burst && left > 0; b++, left--)
        send_knot(full_range ? $urandom_range(0, 63) : $urandom_range(0, KNOTS - 1));
      s_axis_tvalid <= 1'b0;
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Coefficients near unity keep many results off the saturation rails.
  function automatic logic [63:0] mild_coeffs();
    logic [63:0] w;
    w[15:0] = 16'(16384 + $urandom_range(0, 4000) - 2000);
    for (int j = 1; j < 4; j++) w[16*j +: 16] = 16'($urandom_range(0, 8000) - 4000);
    return w;
  endfunction

  function automatic logic [63:0] rand_gain();
    case ($urandom_range(0, 3))
      0: return 64'(16'h8000);
      1: return 64'(16'h7fff);
      default: return 64'(16'($urandom_range(0, 32767) - 16384));
    endcase
  endfunction

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Defaults: both corrections off, indexes 0 to 18 and 63, some past the last knot.
    @(negedge clk_i);
    for (int i = 0; i < 20; i++) send_knot(i == 19 ? 63 : i);
    s_axis_tvalid <= 1'b0;
    drain();

    // Extremes: most positive, most negative and all-ones coefficients, one plane per channel.
    write_reg(REG_WARP0, 64'h7fff_7fff_7fff_7fff);
    write_reg(REG_WARP1, 64'h8000_8000_8000_8000);
    write_reg(REG_WARP2, 64'hffff_ffff_ffff_ffff);
    write_reg(REG_VIG_LOW, 64'h8000_8000_8000_8000);
    write_reg(REG_VIG_HIGH, 64'h8000);
    write_reg(REG_DGAIN, 64'h7fff);
    write_reg(REG_VGAIN, 64'h7fff);
    write_reg(REG_MODE, 64'hf);
    @(negedge clk_i);
    for (int i = 0; i < KNOTS; i++) send_knot(i);
    send_knot(6'h3f);
    s_axis_tvalid <= 1'b0;
    drain();

    // Random settings: every plane count and enable combination.
    for (int phase = 0; phase < 24; phase++) begin
      for (int p = 0; p < 3; p++)
        write_reg(3'(p), $urandom_range(0, 2) == 0 ? rand64() : mild_coeffs());
      write_reg(REG_VIG_LOW, $urandom_range(0, 2) == 0 ? rand64() :
                64'({$urandom} & 64'h0fff_0fff_0fff_0fff));
      write_reg(REG_VIG_HIGH, 64'($urandom_range(0, 65535)));
      write_reg(REG_DGAIN, rand_gain());
      write_reg(REG_VGAIN, rand_gain());
      write_reg(REG_MODE, 64'(phase % 16));
      if (phase == 5) hold_off = 1'b1;
      send_burst(60, $urandom_range(0, 4) == 0);
      drain();
    end

    $display("Sent %0d knot beats over 26 register settings, %0d results checked.",
             knots_sent, seen);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/lrck_pkg.sv
hdl/lrck_recip.sv
hdl/lens_radial_correction_knots.sv
sim/lrck_checker.sv
sim/tb_top.sv
